/* src/session_slot_table_assert.svh */
// ----------------------------------------------------------------------------
// session_slot_table_assert
// Assertion macros shared by the session slot table RTL.
// ----------------------------------------------------------------------------
`ifndef SESSION_SLOT_TABLE_ASSERT_SVH
`define SESSION_SLOT_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants of the session slot table.
// ----------------------------------------------------------------------------
package sst_pkg;

	// default sizing
	localparam int SESSIONS_DEF = 1024;
	localparam int SLOTS_DEF    = 8;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int INDEX_W  = 10;
	localparam int SEQ_W    = 4;
	localparam int ID_W     = 32;
	localparam int STAMP_W  = 64;
	localparam int LIMIT_W  = 11;
	localparam int STATUS_W = 2;

	// sessions_in_use after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUT     = 2'd0,
		OP_DEL_SEQ = 2'd1,
		OP_DEL_ALL = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_BAD_SEQ   = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// one slot as held in a memory row
	typedef struct packed {
		logic                       valid;
		logic signed [ID_W-1:0]     server;
		logic signed [ID_W-1:0]     room;
		logic signed [STAMP_W-1:0]  stamp;
	} slot_t;

endpackage

/* src/session_slot_table.sv */
// On accept the item and its session row are registered; execute then loads the
// result into the output register. A new item is not taken before the last one
// is through the read-modify-write of its session row (read on accept, then
// compare and write back); a stalled result holds the next item in execute,
// which stalls the input. Reset: asynchronous; then a sweep clears the row
// memory, one row a cycle, with the input stalled. Config writes are taken anytime.
// ----------------------------------------------------------------------------
// session_slot_table
// Table of sessions with a fixed number of slots each: put, delete a slot and
// all older ones, delete all, read a slot. One memory row holds a session.
// ----------------------------------------------------------------------------
module session_slot_table
	import sst_pkg::*;
#(
	parameter int SESSIONS = SESSIONS_DEF,
	parameter int SLOTS    = SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [LIMIT_W-1:0]          sessions_in_use,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [OP_W-1:0]             op,
	input  logic [INDEX_W-1:0]          session_index,
	input  logic [SEQ_W-1:0]            seq,
	input  logic signed [ID_W-1:0]      server_id,
	input  logic signed [ID_W-1:0]      room_id,
	input  logic signed [STAMP_W-1:0]   stamp,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [STATUS_W-1:0]         status_code,
	output logic [SEQ_W-1:0]            seq_out,
	output logic [SEQ_W-1:0]            remaining,
	output logic                        slot_occupied,
	output logic signed [ID_W-1:0]      slot_server,
	output logic signed [ID_W-1:0]      slot_room,
	output logic signed [STAMP_W-1:0]   slot_stamp
);

`include "session_slot_table_assert.svh"

	localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef slot_t [SLOTS-1:0] row_t;

	// control and registers
	state_t                 state_q, state_nxt;
	logic [AW-1:0]          clr_q;
	logic [LIMIT_W-1:0]     limit_q;
	logic                   in_accept;
	logic                   out_hold;
	logic                   wr_en;
	logic                   load_out;
	logic [AW-1:0]          wr_addr;
	row_t                   wr_row;

	row_t                   row_mem_q [SESSIONS];
	row_t                   row_s1;
	op_t                    op_s1;
	logic [INDEX_W-1:0]     idx_s1;
	logic [SEQ_W-1:0]       seq_s1;
	logic signed [ID_W-1:0] server_s1;
	logic signed [ID_W-1:0] room_s1;
	logic signed [STAMP_W-1:0] stamp_s1;

	// execute-stage results
	row_t                   new_row;
	logic                   row_write;
	status_t                status_nxt;
	logic [SEQ_W-1:0]       seq_out_nxt;
	logic [SEQ_W-1:0]       remaining_nxt;
	slot_t                  read_nxt;
	logic                   bad_idx;
	logic                   bad_seq;
	logic [SW-1:0]          tgt;
	logic [SW-1:0]          free_slot;
	logic                   free_found;
	logic [SW:0]            free_seq;
	logic [CW-1:0]          live_cnt;
	logic signed [STAMP_W-1:0] held;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;
	assign out_hold  = out_valid && out_stall;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= sessions_in_use;
		end
	end

	// state register and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// next state, handshake and memory write control
	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		wr_en     = 1'b0;
		load_out  = 1'b0;
		wr_addr   = AW'(idx_s1);
		wr_row    = new_row;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_row  = '0;
				if (clr_q == AW'(SESSIONS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!out_hold) begin
					load_out  = 1'b1;
					wr_en     = row_write;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// row memory: one write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_mem_q[wr_addr] <= wr_row;
		end
		if (in_accept) begin
			row_s1 <= row_mem_q[AW'(session_index)];
		end
	end

	// capture the item
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1     <= op_t'(op);
			idx_s1    <= session_index;
			seq_s1    <= seq;
			server_s1 <= server_id;
			room_s1   <= room_id;
			stamp_s1  <= stamp;
		end
	end

	// range checks and slot select
	assign bad_idx = ({1'b0, idx_s1} >= limit_q) || (32'(idx_s1) >= 32'(SESSIONS));
	assign bad_seq = (seq_s1 == '0) || (32'(seq_s1) > 32'(SLOTS));
	assign tgt     = SW'(seq_s1 - SEQ_W'(1));
	assign held    = row_s1[tgt].stamp;

	// first free slot, lowest first
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (!row_s1[s].valid) begin
				free_found = 1'b1;
				free_slot  = SW'(s);
			end
		end
	end
	assign free_seq = {1'b0, free_slot} + (SW+1)'(1);

	// modify the row and form the result
	always_comb begin
		new_row       = row_s1;
		row_write     = 1'b0;
		status_nxt    = STAT_OK;
		seq_out_nxt   = '0;
		remaining_nxt = '0;
		read_nxt      = '0;
		live_cnt      = '0;
		if (bad_idx) begin
			status_nxt = STAT_BAD_INDEX;
		end else begin
			unique case (op_s1)
				OP_PUT: begin
					if (free_found) begin
						new_row[free_slot].valid  = 1'b1;
						new_row[free_slot].server = server_s1;
						new_row[free_slot].room   = room_s1;
						new_row[free_slot].stamp  = stamp_s1;
						row_write   = 1'b1;
						seq_out_nxt = SEQ_W'(free_seq);
					end else begin
						status_nxt = STAT_FULL;
					end
				end
				OP_DEL_ALL: begin
					new_row   = '0;
					row_write = 1'b1;
				end
				OP_DEL_SEQ: begin
					if (bad_seq) begin
						status_nxt = STAT_BAD_SEQ;
					end else begin
						// free the target, then every live slot older than it held
						new_row[tgt] = '0;
						for (int s = 0; s < SLOTS; s++) begin
							if (new_row[s].valid && (new_row[s].stamp < held)) begin
								new_row[s] = '0;
							end
							live_cnt = live_cnt + CW'(new_row[s].valid);
						end
						row_write     = 1'b1;
						remaining_nxt = SEQ_W'(live_cnt);
					end
				end
				OP_READ: begin
					if (bad_seq) begin
						status_nxt = STAT_BAD_SEQ;
					end else begin
						read_nxt = row_s1[tgt];
					end
				end
				default: begin
					status_nxt = STAT_OK;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_code   <= status_nxt;
			seq_out       <= seq_out_nxt;
			remaining     <= remaining_nxt;
			slot_occupied <= read_nxt.valid;
			slot_server   <= read_nxt.server;
			slot_room     <= read_nxt.room;
			slot_stamp    <= read_nxt.stamp;
		end
	end

	// checks
	`SST_ASSERT_NEXT(a_accept_to_exec, in_accept, state_q == ST_EXEC,
		"accepted item did not move to execute")
	`SST_ASSERT_NOW(a_no_write_bad_index, wr_en && state_q == ST_EXEC,
		!bad_idx, "row written for a bad session index")
	`SST_ASSERT_NOW(a_quiet_while_clearing, state_q == ST_CLEAR,
		!out_valid && in_stall, "activity during the clearing pass")
	`SST_ASSERT_NEXT(a_exec_loads_output, state_q == ST_EXEC && !out_hold,
		out_valid && state_q == ST_IDLE, "execute finished without a result")

endmodule
